// ===== design/tfr_pkg.sv =====
// Package: constants, types and decode functions of the telemetry frame receiver.
`timescale 1ns / 1ps

package tfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int FILL_W       = $clog2(BUFFER_DEPTH);
    localparam int STORE_BYTES  = 14;
    localparam int IDLE_W       = 17;
    localparam int TIMEOUT_W    = 16;
    localparam int ADDR_W       = 2;
    localparam int DATA_W       = 32;

    localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [FILL_W:0]      FILL_LIMIT    = (FILL_W + 1)'(BUFFER_DEPTH);

    localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

    localparam logic [7:0] START_BYTE     = 8'h53;
    localparam logic [7:0] END_BYTE       = 8'h45;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h48;
    localparam logic [7:0] TYPE_FIRST     = 8'h02;
    localparam logic [7:0] TYPE_LAST      = 8'h0A;
    localparam logic [7:0] CAU_MOTOR_MAX  = 8'h80;
    localparam logic [7:0] CAU_TORQUE_MAX = 8'h81;
    localparam logic [7:0] CAU_LINK_LOST  = 8'h83;
    localparam logic [7:0] CAU_ANGLE_KILL = 8'h84;

    localparam logic [1:0] EV_FRAME   = 2'd0;
    localparam logic [1:0] EV_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_FULL    = 2'd2;

    localparam logic [3:0] KIND_HEARTBEAT = 4'd0;
    localparam logic [3:0] KIND_CAUTION   = 4'd7;
    localparam logic [3:0] KIND_UNMATCHED = 4'd10;

    localparam logic [2:0] CLASS_MOTOR_MAX  = 3'd0;
    localparam logic [2:0] CLASS_TORQUE_MAX = 3'd1;
    localparam logic [2:0] CLASS_LINK_LOST  = 3'd2;
    localparam logic [2:0] CLASS_ANGLE_KILL = 3'd3;
    localparam logic [2:0] CLASS_UNKNOWN    = 3'd4;

    typedef logic [STORE_BYTES-1:0][7:0] frame_store_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  msg_kind;
        logic [7:0]  type_byte;
        logic [2:0]  caution_class;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
    } result_t;

    function automatic logic [3:0] kind_of(input logic [7:0] t);
        logic [7:0] d;
        d = t - 8'd1;
        if (t == TYPE_HEARTBEAT)
            return KIND_HEARTBEAT;
        if (t >= TYPE_FIRST && t <= TYPE_LAST)
            return d[3:0];
        return KIND_UNMATCHED;
    endfunction

    function automatic logic [2:0] caution_of(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CAU_MOTOR_MAX:  r = CLASS_MOTOR_MAX;
            CAU_TORQUE_MAX: r = CLASS_TORQUE_MAX;
            CAU_LINK_LOST:  r = CLASS_LINK_LOST;
            CAU_ANGLE_KILL: r = CLASS_ANGLE_KILL;
            default:        r = CLASS_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tfr_in_if.sv =====
// Interface: input channel carrying link bytes and millisecond ticks.
`timescale 1ns / 1ps

interface tfr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// ===== design/tfr_out_if.sv =====
// Interface: output channel carrying decoded frames and drop warnings.
`timescale 1ns / 1ps

interface tfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [3:0]  msg_kind;
    logic [7:0]  type_byte;
    logic [2:0]  caution_class;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;

    modport source (output valid, output event_res, output msg_kind, output type_byte,
                    output caution_class, output word_a, output word_b, output word_c,
                    input ready);
    modport sink   (input valid, input event_res, input msg_kind, input type_byte,
                    input caution_class, input word_a, input word_b, input word_c,
                    output ready);
endinterface

// ===== design/telemetry_frame_receiver_top.sv =====
// Top level: telemetry frame receiver with APB timeout register.
// Input register holds each accepted transaction; the result register holds its outcome.
// Throughput: one byte or tick per cycle, set by the single input register feeding the
// framing logic and the result register; ready drops only while a result is held.
// Reset: rst_n clears the frame state, the byte store and both valid flags at once;
// the timeout register returns to 2000 ticks. No clearing pass follows reset.
`timescale 1ns / 1ps

module telemetry_frame_receiver_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tfr_pkg::ADDR_W-1:0] paddr,
    input  logic [tfr_pkg::DATA_W-1:0] pwdata,
    output logic [tfr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    tfr_in_if.sink                     in_ch,
    tfr_out_if.source                  out_ch
);

    logic [tfr_pkg::TIMEOUT_W-1:0] timeout_ticks;

    tfr_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .timeout_ticks (timeout_ticks)
    );

    tfr_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_ticks),
        .in_ch         (in_ch),
        .out_ch        (out_ch)
    );

`ifndef SYNTHESIS
    a_drop_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res != tfr_pkg::EV_FRAME |->
            out_ch.msg_kind == '0 && out_ch.type_byte == '0 &&
            out_ch.caution_class == '0 && out_ch.word_a == '0 &&
            out_ch.word_b == '0 && out_ch.word_c == '0)
        else $error("drop event carries nonzero payload");

    a_caution_only_on_caution: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res == tfr_pkg::EV_FRAME &&
            out_ch.caution_class != tfr_pkg::CLASS_UNKNOWN |->
            out_ch.msg_kind == tfr_pkg::KIND_CAUTION)
        else $error("caution class set on a non-caution frame");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res == tfr_pkg::EV_FRAME |->
            out_ch.msg_kind <= tfr_pkg::KIND_UNMATCHED)
        else $error("message kind out of range");

    a_timeout_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == tfr_pkg::ADDR_TIMEOUT |=>
            timeout_ticks == $past(pwdata[tfr_pkg::TIMEOUT_W-1:0]))
        else $error("timeout register did not take the written value");
`endif

endmodule

// ===== design/tfr_cfg.sv =====
// APB register block holding the idle timeout.
`timescale 1ns / 1ps

module tfr_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfr_pkg::ADDR_W-1:0]    paddr,
    input  logic [tfr_pkg::DATA_W-1:0]    pwdata,
    output logic [tfr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [tfr_pkg::TIMEOUT_W-1:0] timeout_ticks
);

    logic [tfr_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == tfr_pkg::ADDR_TIMEOUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tfr_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            timeout_reg <= pwdata[tfr_pkg::TIMEOUT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == tfr_pkg::ADDR_TIMEOUT)
        begin
            prdata[tfr_pkg::TIMEOUT_W-1:0] = timeout_reg;
        end
    end

    assign timeout_ticks = timeout_reg;

endmodule

// ===== design/tfr_decode.sv =====
// Frame decoder: type byte to message kind, caution class and payload words.
`timescale 1ns / 1ps

module tfr_decode
(
    input  tfr_pkg::frame_store_t store,
    output tfr_pkg::result_t      frame
);

    logic [3:0] kind;

    assign kind = tfr_pkg::kind_of(store[1]);

    always_comb
    begin
        frame.event_res     = tfr_pkg::EV_FRAME;
        frame.msg_kind      = kind;
        frame.type_byte     = store[1];
        frame.caution_class = (kind == tfr_pkg::KIND_CAUTION) ?
                              tfr_pkg::caution_of(store[2]) : tfr_pkg::CLASS_UNKNOWN;
        frame.word_a        = {store[5], store[4], store[3], store[2]};
        frame.word_b        = {store[9], store[8], store[7], store[6]};
        frame.word_c        = {store[13], store[12], store[11], store[10]};
    end

endmodule

// ===== design/tfr_engine.sv =====
// Frame engine: input register, framing state, byte store and result register.
`timescale 1ns / 1ps

module tfr_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tfr_pkg::TIMEOUT_W-1:0] timeout_ticks,
    tfr_in_if.sink                        in_ch,
    tfr_out_if.source                     out_ch
);

    logic                          in_vld_reg;
    logic                          cmd_reg;
    logic [7:0]                    byte_reg;
    logic [tfr_pkg::FILL_W-1:0]    fill_reg;
    logic [tfr_pkg::FILL_W-1:0]    fill_next;
    logic [tfr_pkg::IDLE_W-1:0]    idle_reg;
    logic [tfr_pkg::IDLE_W-1:0]    idle_next;
    tfr_pkg::frame_store_t         store_reg;
    tfr_pkg::frame_store_t         store_next;
    logic                          out_vld_reg;
    logic                          out_vld_next;
    tfr_pkg::result_t              res_reg;
    tfr_pkg::result_t              res_next;
    tfr_pkg::result_t              frame;

    logic                          in_acc;
    logic                          advance;
    logic                          active;
    logic                          take_byte;
    logic                          is_end;
    logic [tfr_pkg::FILL_W:0]      fill_inc;
    logic [tfr_pkg::IDLE_W-1:0]    idle_inc;
    logic                          emit_frame;
    logic                          emit_full;
    logic                          emit_timeout;
    logic                          emit;

    // Process the held transaction once the result register can take its outcome
    assign advance  = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_acc   = in_ch.valid && in_ch.ready;

    assign active    = (fill_reg != '0);
    assign take_byte = !cmd_reg && (active || byte_reg == tfr_pkg::START_BYTE);
    assign is_end    = (byte_reg == tfr_pkg::END_BYTE);
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign idle_inc  = (idle_reg == tfr_pkg::IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    assign emit_frame   = take_byte && is_end;
    assign emit_full    = take_byte && !is_end && (fill_inc >= tfr_pkg::FILL_LIMIT);
    assign emit_timeout = cmd_reg && active &&
                          (idle_inc > {{(tfr_pkg::IDLE_W - tfr_pkg::TIMEOUT_W){1'b0}},
                                       timeout_ticks});
    assign emit = emit_frame || emit_full || emit_timeout;

    // Write the byte into the store ahead of decode, so a closing byte is seen
    always_comb
    begin
        store_next = store_reg;
        for (int i = 0; i < tfr_pkg::STORE_BYTES; i++)
        begin
            if (take_byte && fill_reg == tfr_pkg::FILL_W'(i))
            begin
                store_next[i] = byte_reg;
            end
        end
    end

    tfr_decode u_decode
    (
        .store (store_next),
        .frame (frame)
    );

    always_comb
    begin
        fill_next = fill_reg;
        idle_next = idle_reg;
        res_next  = '0;
        if (take_byte)
        begin
            idle_next = '0;
            if (emit_frame || emit_full)
            begin
                fill_next = '0;
            end
            else
            begin
                fill_next = fill_inc[tfr_pkg::FILL_W-1:0];
            end
        end
        else if (cmd_reg && active)
        begin
            if (emit_timeout)
            begin
                fill_next = '0;
                idle_next = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end

        if (emit_frame)
        begin
            res_next = frame;
        end
        else if (emit_full)
        begin
            res_next.event_res = tfr_pkg::EV_FULL;
        end
        else
        begin
            res_next.event_res = tfr_pkg::EV_TIMEOUT;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_vld_next = emit;
        end
        else if (out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fill_reg    <= '0;
            idle_reg    <= '0;
            store_reg   <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (in_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                fill_reg  <= fill_next;
                idle_reg  <= idle_next;
                store_reg <= store_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= in_ch.command;
            byte_reg <= in_ch.rx_byte;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.event_res     = res_reg.event_res;
    assign out_ch.msg_kind      = res_reg.msg_kind;
    assign out_ch.type_byte     = res_reg.type_byte;
    assign out_ch.caution_class = res_reg.caution_class;
    assign out_ch.word_a        = res_reg.word_a;
    assign out_ch.word_b        = res_reg.word_b;
    assign out_ch.word_c        = res_reg.word_c;

endmodule
